/* sv/wli_pkg.sv */
package wli_pkg;

  // Coordinate format: signed fixed point with 8 fraction bits.
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned RES_W     = 16;
  localparam int unsigned MAX_STEPS = 64;

  localparam int unsigned STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int unsigned DELTA_W = COORD_W + 1;
  localparam int unsigned CNT_W   = $clog2(DELTA_W);

  // Deltas are clamped to this magnitude before squaring.
  localparam int unsigned CAP_W     = 24;
  localparam int unsigned DELTA_CAP = 32'd1 << (CAP_W - 1);
  localparam int unsigned SQ_W      = 2 * CAP_W;
  localparam int unsigned SUM_W     = SQ_W + 2;

  // Running spacing register: up to MAX_STEPS + 1 times the resolution.
  localparam int unsigned T_W = RES_W + STEP_W;

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(128);

  localparam int unsigned NUM_AXES = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic       store_prev;
    logic       load;
    logic       sq_step;
    logic [1:0] axis;
    logic       search_init;
    logic       search_step;
    logic       div_init;
    logic       div_step;
    logic       emit_step;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic last;
  } stat_t;

endpackage

/* sv/waypoint_line_interpolator_top.sv */
// Linear waypoint interpolator. Waypoints arrive one word at a time as signed
// fixed-point coordinates with 8 fraction bits; a word with new_path set, or the
// first word after reset, is only stored as the start of a path and produces
// nothing. Every further waypoint closes a segment from the stored one: the block
// counts the steps as the largest k from 1 to 64 with k times the resolution no
// longer than the segment length, then emits k points, start + trunc(j*delta/k)
// for j from 0 to k-1, the last flagged by last_in_run. The segment end is not
// emitted; it becomes the start of the next segment. One waypoint is processed at
// a time and in_ready is high only while the block is idle. A segment passes
// through the summation of the squared axis deltas, the step-count search, which
// tries one candidate count a cycle on a single multiplier, the bit-serial
// division of each axis delta by the step count, and emission at one point per
// cycle while out_ready is held high, before the block is idle again.
// The resolution register resets to 0.5 and may only be written while idle.
module waypoint_line_interpolator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [wli_pkg::RES_W-1:0]  cfg_resolution_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       new_path_i,
  input  wli_pkg::coord_t            pos_x_i,
  input  wli_pkg::coord_t            pos_y_i,
  input  wli_pkg::coord_t            pos_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output wli_pkg::coord_t            out_x_o,
  output wli_pkg::coord_t            out_y_o,
  output wli_pkg::coord_t            out_z_o,
  output logic                       last_in_run_o
);

  wli_pkg::cmd_t  cmd;
  wli_pkg::stat_t stat;

  // The resolution register can always take a word.
  assign cfg_ready_o = 1'b1;

  // The controller sequences square summation, step search, division and emission.
  wli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .new_path_i  (new_path_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // The datapath holds the waypoints, the arithmetic and the output point.
  wli_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_resolution_i (cfg_resolution_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o),
    .last_in_run_o    (last_in_run_o)
  );

endmodule

/* sv/wli_ctrl.sv */
module wli_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           new_path_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wli_pkg::cmd_t  cmd_o,
  input  wli_pkg::stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_SEARCH,
    S_DIV,
    S_EMIT
  } state_e;

  localparam logic [wli_pkg::CNT_W-1:0] SQ_LAST  = wli_pkg::CNT_W'(wli_pkg::NUM_AXES - 1);
  localparam logic [wli_pkg::CNT_W-1:0] DIV_LAST = wli_pkg::CNT_W'(wli_pkg::DELTA_W - 1);

  state_e                     state_q, state_d;
  logic [wli_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       have_prev_q, have_prev_d;
  logic                       in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    cmd_o       = '0;
    cmd_o.axis  = cnt_q[1:0];
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (new_path_i || !have_prev_q) begin
            cmd_o.store_prev = 1'b1;
            have_prev_d      = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == SQ_LAST) begin
          cmd_o.search_init = 1'b1;
          state_d           = S_SEARCH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.search_done) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.last) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

/* sv/wli_dp.sv */
module wli_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wli_pkg::cmd_t                 cmd_i,
  output wli_pkg::stat_t                stat_o,
  input  logic                          cfg_valid_i,
  input  logic [wli_pkg::RES_W-1:0]     cfg_resolution_i,
  input  wli_pkg::coord_t               pos_x_i,
  input  wli_pkg::coord_t               pos_y_i,
  input  wli_pkg::coord_t               pos_z_i,
  output wli_pkg::coord_t               out_x_o,
  output wli_pkg::coord_t               out_y_o,
  output wli_pkg::coord_t               out_z_o,
  output logic                          last_in_run_o
);

  localparam int unsigned NA = wli_pkg::NUM_AXES;
  localparam int unsigned DW = wli_pkg::DELTA_W;
  localparam int unsigned SW = wli_pkg::STEP_W;

  logic [wli_pkg::RES_W-1:0] res_q;

  wli_pkg::coord_t pos_in [NA];
  wli_pkg::coord_t prev_q [NA];
  wli_pkg::coord_t cur_q  [NA];
  logic            neg_q  [NA];
  logic [DW-1:0]   mag_q  [NA];
  logic [DW-1:0]   quo_q  [NA];
  logic [SW-1:0]   rem_q  [NA];
  logic [DW-1:0]   accq_q [NA];
  logic [SW-1:0]   accr_q [NA];

  logic signed [DW-1:0] diff   [NA];
  logic [DW-1:0]        mag_d  [NA];
  logic [SW:0]          rs     [NA];
  logic                 qbit   [NA];
  logic [SW:0]          rsum   [NA];
  logic                 wrap   [NA];
  logic signed [DW:0]   offset [NA];
  logic signed [DW:0]   point  [NA];

  logic [wli_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [DW-1:0]               sel_mag;
  logic [wli_pkg::CAP_W-1:0]   clamped;
  logic [wli_pkg::SQ_W-1:0]    sq;
  logic [wli_pkg::T_W-1:0]     t_q;
  logic [2*wli_pkg::T_W-1:0]   tt;
  logic [SW-1:0]               steps_q;
  logic [SW-1:0]               j_q;
  logic                        go;

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  // Per-axis delta, its sign and magnitude; division and accumulation steps.
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      diff[a]  = DW'(pos_in[a]) - DW'(prev_q[a]);
      mag_d[a] = diff[a][DW-1] ? DW'(-diff[a]) : DW'(diff[a]);
      rs[a]    = {rem_q[a], quo_q[a][DW-1]};
      qbit[a]  = (rs[a] >= (SW+1)'(steps_q));
      rsum[a]  = (SW+1)'(accr_q[a]) + (SW+1)'(rem_q[a]);
      wrap[a]  = (rsum[a] >= (SW+1)'(steps_q));
      offset[a] = neg_q[a] ? -$signed({1'b0, accq_q[a]}) : $signed({1'b0, accq_q[a]});
      point[a]  = (DW+1)'(prev_q[a]) + offset[a];
    end
  end

  // Sum of clamped squares, one axis a cycle.
  always_comb begin
    sel_mag = mag_q[cmd_i.axis];
    clamped = (sel_mag > DW'(wli_pkg::DELTA_CAP)) ? wli_pkg::CAP_W'(wli_pkg::DELTA_CAP)
                                                  : sel_mag[wli_pkg::CAP_W-1:0];
    sq      = clamped * clamped;
    sum_d   = ((cmd_i.axis == 2'd0) ? '0 : sum_q) + wli_pkg::SUM_W'(sq);
  end

  assign tt = t_q * t_q;
  assign go = (steps_q < SW'(wli_pkg::MAX_STEPS)) && (wli_pkg::SUM_W'(tt) <= sum_q);

  assign stat_o.search_done = !go;
  assign stat_o.last        = (j_q == steps_q - SW'(1));

  assign out_x_o       = point[0][wli_pkg::COORD_W-1:0];
  assign out_y_o       = point[1][wli_pkg::COORD_W-1:0];
  assign out_z_o       = point[2][wli_pkg::COORD_W-1:0];
  assign last_in_run_o = stat_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= wli_pkg::RES_RESET;
    end else if (cfg_valid_i) begin
      res_q <= cfg_resolution_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      sum_q <= sum_d;
    end
    if (cmd_i.search_init) begin
      steps_q <= SW'(1);
      t_q     <= wli_pkg::T_W'({res_q, 1'b0});
    end else if (cmd_i.search_step && go) begin
      steps_q <= steps_q + SW'(1);
      t_q     <= t_q + wli_pkg::T_W'(res_q);
    end
    if (cmd_i.div_init) begin
      j_q <= '0;
    end else if (cmd_i.emit_step) begin
      j_q <= j_q + SW'(1);
    end
    for (int a = 0; a < NA; a++) begin
      if (cmd_i.store_prev) begin
        prev_q[a] <= pos_in[a];
      end else if (cmd_i.commit) begin
        prev_q[a] <= cur_q[a];
      end
      if (cmd_i.load) begin
        cur_q[a] <= pos_in[a];
        neg_q[a] <= diff[a][DW-1];
        mag_q[a] <= mag_d[a];
      end
      if (cmd_i.div_init) begin
        quo_q[a]  <= mag_q[a];
        rem_q[a]  <= '0;
        accq_q[a] <= '0;
        accr_q[a] <= '0;
      end else if (cmd_i.div_step) begin
        quo_q[a] <= {quo_q[a][DW-2:0], qbit[a]};
        rem_q[a] <= qbit[a] ? SW'(rs[a] - (SW+1)'(steps_q)) : SW'(rs[a]);
      end else if (cmd_i.emit_step) begin
        accr_q[a] <= wrap[a] ? SW'(rsum[a] - (SW+1)'(steps_q)) : SW'(rsum[a]);
        accq_q[a] <= accq_q[a] + quo_q[a] + DW'(wrap[a]);
      end
    end
  end

endmodule
